/* design/pbrq_pkg.sv */
// Shared types and constants for the priority bitmap ready-queue scheduler.
// No dependencies; used by pbrq_queue_core, the top level and the testbench.
`timescale 1ns / 1ps

package pbrq_pkg;

    localparam int THREAD_ID_W = 6;
    localparam int PRIO_REQ_W  = 6;
    localparam int BEST_PRIO_W = 5;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;

    // request kinds carried on s_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [THREAD_ID_W-1:0] thread_id;
        logic [PRIO_REQ_W-1:0]  priority_req;
        logic                   is_yield;
        logic                   is_current;
    } pbrq_req_t;

    typedef struct packed {
        logic                   became_running;
        logic                   any_ready;
        logic [THREAD_ID_W-1:0] best_thread;
        logic [BEST_PRIO_W-1:0] best_priority;
    } pbrq_result_t;

endpackage

/* design/pbrq_prio_enc.sv */
// Lowest-set-bit priority encoder over the level bitmap.
// Depends on nothing but its width parameter.
`timescale 1ns / 1ps

module pbrq_prio_enc #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]         bits,
    output logic                     any,
    output logic [$clog2(WIDTH)-1:0] index
);

    localparam int IW = $clog2(WIDTH);

    always_comb
    begin
        index = '0;
        // scan downwards so the lowest set bit wins
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                index = IW'(i);
            end
        end
    end

    assign any = |bits;

endmodule

/* design/pbrq_queue_core.sv */
// Per-level doubly linked ready queues, level bitmap and result lookup.
// Depends on pbrq_pkg and pbrq_prio_enc.
`timescale 1ns / 1ps

module pbrq_queue_core #(
    parameter int NUM_LEVELS  = 32,
    parameter int NUM_THREADS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [pbrq_pkg::THREAD_ID_W-1:0] load_thread,
    input  logic                             fire,
    input  pbrq_pkg::pbrq_req_t              req,
    output pbrq_pkg::pbrq_result_t           result
);

    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = $clog2(NUM_LEVELS);

    logic [NUM_LEVELS-1:0]  level_bitmap_reg;
    logic [NUM_LEVELS-1:0]  level_bitmap_next;
    logic [TW-1:0]          level_head_reg   [NUM_LEVELS];
    logic [TW-1:0]          level_head_next  [NUM_LEVELS];
    logic [TW-1:0]          level_tail_reg   [NUM_LEVELS];
    logic [TW-1:0]          level_tail_next  [NUM_LEVELS];
    logic [TW-1:0]          next_link_mem    [NUM_THREADS];
    logic [TW-1:0]          prev_link_mem    [NUM_THREADS];
    logic [LW-1:0]          thread_level_mem [NUM_THREADS];
    logic [NUM_THREADS-1:0] thread_queued_reg;
    logic [NUM_THREADS-1:0] thread_queued_next;

    // link entries of the request's own thread, read as the request is taken
    logic [TW-1:0] load_t;
    logic [TW-1:0] nx_raw_reg;
    logic [TW-1:0] pv_raw_reg;
    logic [LW-1:0] lv_raw_reg;
    logic          nx_hit_next;
    logic          pv_hit_next;
    logic          lv_hit_next;
    logic [TW-1:0] nx_fwd_next;
    logic [TW-1:0] pv_fwd_next;
    logic          nx_hit_reg;
    logic          pv_hit_reg;
    logic          lv_hit_reg;
    logic [TW-1:0] nx_fwd_reg;
    logic [TW-1:0] pv_fwd_reg;
    logic [LW-1:0] lv_fwd_reg;

    // link memory write ports: port 0 from the unlink, port 1 from the link
    logic          nl_we0;
    logic [TW-1:0] nl_a0;
    logic [TW-1:0] nl_d0;
    logic          nl_we1;
    logic [TW-1:0] nl_a1;
    logic [TW-1:0] nl_d1;
    logic          pl_we0;
    logic [TW-1:0] pl_a0;
    logic [TW-1:0] pl_d0;
    logic          pl_we1;
    logic [TW-1:0] pl_a1;
    logic [TW-1:0] pl_d1;

    logic          is_insert;
    logic          hold_running;
    logic          t_ok;
    logic          prio_ok;
    logic [TW-1:0] t;
    logic [LW-1:0] lv_l;
    logic [LW-1:0] lv_u;
    logic [TW-1:0] nx;
    logic [TW-1:0] pv;
    logic [TW-1:0] u_head;
    logic [TW-1:0] u_tail;
    logic          do_unlink;
    logic          do_link;
    logic          best_any;
    logic [LW-1:0] best_lv;
    logic [TW-1:0] best_head;

    assign is_insert    = (req.req_type == pbrq_pkg::REQ_INSERT);
    assign hold_running = is_insert && req.is_current;
    assign t_ok         = 32'(req.thread_id) < NUM_THREADS;
    assign prio_ok      = 32'(req.priority_req) < NUM_LEVELS;
    assign t            = TW'(32'(req.thread_id));
    assign lv_l         = LW'(32'(req.priority_req));
    assign load_t       = TW'(32'(load_thread));
    assign lv_u         = lv_hit_reg ? lv_fwd_reg : lv_raw_reg;
    assign nx           = nx_hit_reg ? nx_fwd_reg : nx_raw_reg;
    assign pv           = pv_hit_reg ? pv_fwd_reg : pv_raw_reg;
    assign u_head       = level_head_reg[lv_u];
    assign u_tail       = level_tail_reg[lv_u];
    assign do_unlink    = t_ok && !hold_running && thread_queued_reg[t];
    assign do_link      = t_ok && !hold_running && is_insert && prio_ok;

    always_comb
    begin
        level_bitmap_next  = level_bitmap_reg;
        level_head_next    = level_head_reg;
        level_tail_next    = level_tail_reg;
        thread_queued_next = thread_queued_reg;
        nl_we0 = 1'b0;
        nl_a0  = pv;
        nl_d0  = nx;
        pl_we0 = 1'b0;
        pl_a0  = nx;
        pl_d0  = pv;
        nl_we1 = 1'b0;
        nl_a1  = t;
        nl_d1  = t;
        pl_we1 = 1'b0;
        pl_a1  = t;
        pl_d1  = t;

        if (do_unlink)
        begin
            if (u_head == t && u_tail == t)
            begin
                level_bitmap_next[lv_u] = 1'b0;
            end
            else if (u_head == t)
            begin
                level_head_next[lv_u] = nx;
            end
            else if (u_tail == t)
            begin
                level_tail_next[lv_u] = pv;
            end
            else
            begin
                nl_we0 = 1'b1;
                pl_we0 = 1'b1;
            end
            thread_queued_next[t] = 1'b0;
        end

        // link sees the queue as the unlink left it; its link entries never
        // coincide with the neighbours that the unlink joins
        if (do_link)
        begin
            if (!level_bitmap_next[lv_l])
            begin
                level_head_next[lv_l]   = t;
                level_tail_next[lv_l]   = t;
                level_bitmap_next[lv_l] = 1'b1;
            end
            else if (req.is_yield)
            begin
                nl_we1 = 1'b1;
                nl_a1  = level_tail_next[lv_l];
                nl_d1  = t;
                pl_we1 = 1'b1;
                pl_a1  = t;
                pl_d1  = level_tail_next[lv_l];
                level_tail_next[lv_l] = t;
            end
            else
            begin
                pl_we1 = 1'b1;
                pl_a1  = level_head_next[lv_l];
                pl_d1  = t;
                nl_we1 = 1'b1;
                nl_a1  = t;
                nl_d1  = level_head_next[lv_l];
                level_head_next[lv_l] = t;
            end
            thread_queued_next[t] = 1'b1;
        end
    end

    // forward the entries that the request in flight writes at the taking edge
    always_comb
    begin
        nx_hit_next = 1'b0;
        nx_fwd_next = nl_d0;
        pv_hit_next = 1'b0;
        pv_fwd_next = pl_d0;
        if (fire && nl_we1 && nl_a1 == load_t)
        begin
            nx_hit_next = 1'b1;
            nx_fwd_next = nl_d1;
        end
        else if (fire && nl_we0 && nl_a0 == load_t)
        begin
            nx_hit_next = 1'b1;
            nx_fwd_next = nl_d0;
        end
        if (fire && pl_we1 && pl_a1 == load_t)
        begin
            pv_hit_next = 1'b1;
            pv_fwd_next = pl_d1;
        end
        else if (fire && pl_we0 && pl_a0 == load_t)
        begin
            pv_hit_next = 1'b1;
            pv_fwd_next = pl_d0;
        end
        lv_hit_next = fire && do_link && (t == load_t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_bitmap_reg  <= '0;
            thread_queued_reg <= '0;
        end
        else if (fire)
        begin
            level_bitmap_reg  <= level_bitmap_next;
            thread_queued_reg <= thread_queued_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            level_head_reg <= level_head_next;
            level_tail_reg <= level_tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && nl_we0)
        begin
            next_link_mem[nl_a0] <= nl_d0;
        end
        if (fire && nl_we1)
        begin
            next_link_mem[nl_a1] <= nl_d1;
        end
        if (fire && pl_we0)
        begin
            prev_link_mem[pl_a0] <= pl_d0;
        end
        if (fire && pl_we1)
        begin
            prev_link_mem[pl_a1] <= pl_d1;
        end
        if (fire && do_link)
        begin
            thread_level_mem[t] <= lv_l;
        end
        if (load)
        begin
            nx_raw_reg <= next_link_mem[load_t];
            pv_raw_reg <= prev_link_mem[load_t];
            lv_raw_reg <= thread_level_mem[load_t];
            nx_hit_reg <= nx_hit_next;
            pv_hit_reg <= pv_hit_next;
            lv_hit_reg <= lv_hit_next;
            nx_fwd_reg <= nx_fwd_next;
            pv_fwd_reg <= pv_fwd_next;
            lv_fwd_reg <= lv_l;
        end
    end

    pbrq_prio_enc #(
        .WIDTH (NUM_LEVELS)
    ) u_prio_enc (
        .bits  (level_bitmap_next),
        .any   (best_any),
        .index (best_lv)
    );

    assign best_head = level_head_next[best_lv];

    always_comb
    begin
        result.became_running = hold_running;
        result.any_ready      = best_any;
        result.best_thread    = best_any ? pbrq_pkg::THREAD_ID_W'(32'(best_head)) : '0;
        result.best_priority  = best_any ? pbrq_pkg::BEST_PRIO_W'(32'(best_lv)) : '0;
    end

    a_link_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && do_link |=> level_bitmap_reg[$past(lv_l)])
        else $error("linked level bit not set");

    a_remove_dequeues: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !is_insert && t_ok |=> !thread_queued_reg[$past(t)])
        else $error("removed thread still queued");

    a_bad_thread_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !t_ok |=> $stable(level_bitmap_reg) && $stable(thread_queued_reg))
        else $error("out-of-range thread changed queue state");

endmodule

/* design/priority_bitmap_ready_queues.sv */
// Top level of the priority bitmap ready-queue scheduler: stream ports,
// input register and result register. Depends on pbrq_pkg and pbrq_queue_core.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata request fields, s_tuser request kind
//   m_*      out  m_tvalid/m_tready  m_tdata result fields
//
// One request per cycle while the result is not stalled; a request waits in the
// input register while the link entries of its thread are read, and its result
// is then held in the result register. The update and lookup run in one pass.
// Reset clears the level bitmap and the queued flags; link and head entries
// stay undefined until written. A stalled result holds the input register,
// which in turn drops s_tready.
`timescale 1ns / 1ps

module priority_bitmap_ready_queues #(
    parameter int NUM_LEVELS  = 32,
    parameter int NUM_THREADS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // thread_id[5:0], priority_req[11:6], is_yield[12], is_current[13], zero[15:14]
    input  logic [pbrq_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // became_running[0], any_ready[1], best_thread[7:2], best_priority[12:8],
    // zero[15:13]
    output logic [pbrq_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic                   in_valid_reg;
    pbrq_pkg::pbrq_req_t    in_req_reg;
    logic                   out_valid_reg;
    pbrq_pkg::pbrq_result_t out_result_reg;
    pbrq_pkg::pbrq_result_t core_result;
    logic                   advance;
    logic                   s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_req_reg.req_type     <= s_tuser[0];
            in_req_reg.thread_id    <= s_tdata[5:0];
            in_req_reg.priority_req <= s_tdata[11:6];
            in_req_reg.is_yield     <= s_tdata[12];
            in_req_reg.is_current   <= s_tdata[13];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    pbrq_queue_core #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) u_queue_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s_fire),
        .load_thread (s_tdata[5:0]),
        .fire        (advance),
        .req         (in_req_reg),
        .result      (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_result_reg.best_priority,
                       out_result_reg.best_thread,
                       out_result_reg.any_ready,
                       out_result_reg.became_running};

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_result_reg.any_ready |->
            out_result_reg.best_thread == '0 && out_result_reg.best_priority == '0)
        else $error("empty bitmap gave a non-zero best entry");

    a_remove_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_req_reg.req_type == pbrq_pkg::REQ_REMOVE |=>
            !out_result_reg.became_running)
        else $error("remove reported a running thread");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("stalled request lost from input register");

endmodule

/* tb/priority_bitmap_ready_queues_tb.sv */
// Self-checking testbench for priority_bitmap_ready_queues: random request stream with
// stalls on both sides, checked against an in-bench ready-queue scheduler model.
// Depends on pbrq_pkg and the design files of the block.
`timescale 1ns / 1ps

module priority_bitmap_ready_queues_tb;

    localparam int NUM_LEVELS  = 32;
    localparam int NUM_THREADS = 64;
    localparam int RANDOM_REQS = 1300;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // thread_id[5:0], priority_req[11:6], is_yield[12], is_current[13], zero[15:14]
    logic [pbrq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // req_type[0]
    logic [0:0]                     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // became_running[0], any_ready[1], best_thread[7:2], best_priority[12:8], zero[15:13]
    logic [pbrq_pkg::M_TDATA_W-1:0] m_tdata;

    priority_bitmap_ready_queues #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // scheduler state as the block should hold it
    logic [NUM_LEVELS-1:0]            ready_mask = '0;
    logic [pbrq_pkg::THREAD_ID_W-1:0] lvl_head [NUM_LEVELS];
    logic [pbrq_pkg::THREAD_ID_W-1:0] lvl_tail [NUM_LEVELS];
    logic [pbrq_pkg::THREAD_ID_W-1:0] nxt_link [NUM_THREADS];
    logic [pbrq_pkg::THREAD_ID_W-1:0] prv_link [NUM_THREADS];
    logic [pbrq_pkg::BEST_PRIO_W-1:0] thr_level [NUM_THREADS];
    logic                             thr_queued [NUM_THREADS] = '{default: 1'b0};

    pbrq_pkg::pbrq_req_t    pending_requests[$];
    pbrq_pkg::pbrq_result_t predicted_views[$];

    pbrq_pkg::pbrq_req_t tx_req;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  total_requests = 0;
    int  accepted_count = 0;
    int  checked_count = 0;
    int  error_count = 0;
    int  insert_count = 0;
    int  remove_count = 0;
    int  running_count = 0;
    int  deepest_level = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    task automatic detach_thread(input logic [pbrq_pkg::THREAD_ID_W-1:0] t);
        logic [pbrq_pkg::BEST_PRIO_W-1:0] lv;
        logic [pbrq_pkg::THREAD_ID_W-1:0] h, tl, nx, pv;
        if (!thr_queued[t])
            return;
        lv = thr_level[t];
        h  = lvl_head[lv];
        tl = lvl_tail[lv];
        nx = nxt_link[t];
        pv = prv_link[t];
        if (h == t && tl == t)
            ready_mask[lv] = 1'b0;
        else if (h == t)
            lvl_head[lv] = nx;
        else if (tl == t)
            lvl_tail[lv] = pv;
        else
        begin
            nxt_link[pv] = nx;
            prv_link[nx] = pv;
        end
        thr_queued[t] = 1'b0;
    endtask

    task automatic attach_thread(input logic [pbrq_pkg::THREAD_ID_W-1:0] t,
                                 input logic [pbrq_pkg::BEST_PRIO_W-1:0] lv,
                                 input logic at_tail);
        logic [pbrq_pkg::THREAD_ID_W-1:0] h, tl;
        if (!ready_mask[lv])
        begin
            lvl_head[lv]   = t;
            lvl_tail[lv]   = t;
            ready_mask[lv] = 1'b1;
        end
        else if (at_tail)
        begin
            tl           = lvl_tail[lv];
            nxt_link[tl] = t;
            prv_link[t]  = tl;
            lvl_tail[lv] = t;
        end
        else
        begin
            h            = lvl_head[lv];
            prv_link[h]  = t;
            nxt_link[t]  = h;
            lvl_head[lv] = t;
        end
        thr_level[t]  = lv;
        thr_queued[t] = 1'b1;
    endtask

    // apply one request and record the scheduler view it should leave behind
    task automatic update_ready_queues(input pbrq_pkg::pbrq_req_t r);
        pbrq_pkg::pbrq_result_t view;
        bit                     found;
        int                     depth;
        view  = '0;
        found = 1'b0;
        depth = 0;
        if (r.req_type == pbrq_pkg::REQ_INSERT && r.is_current)
        begin
            view.became_running = 1'b1;
            running_count++;
        end
        else
        begin
            detach_thread(r.thread_id);
            if (r.req_type == pbrq_pkg::REQ_INSERT && r.priority_req < NUM_LEVELS)
                attach_thread(r.thread_id, r.priority_req[pbrq_pkg::BEST_PRIO_W-1:0],
                              r.is_yield);
        end
        if (r.req_type == pbrq_pkg::REQ_INSERT)
            insert_count++;
        else
            remove_count++;
        for (int lv = 0; lv < NUM_LEVELS; lv++)
        begin
            if (ready_mask[lv] && !found)
            begin
                found              = 1'b1;
                view.any_ready     = 1'b1;
                view.best_thread   = lvl_head[lv];
                view.best_priority = pbrq_pkg::BEST_PRIO_W'(lv);
            end
        end
        for (int t = 0; t < NUM_THREADS; t++)
            if (thr_queued[t])
                depth++;
        if (depth > deepest_level)
            deepest_level = depth;
        predicted_views.push_back(view);
    endtask

    task automatic queue_request(input logic kind, input int tid, input int prio,
                                 input logic yld, input logic cur);
        pbrq_pkg::pbrq_req_t r;
        r.req_type     = kind;
        r.thread_id    = pbrq_pkg::THREAD_ID_W'(tid);
        r.priority_req = pbrq_pkg::PRIO_REQ_W'(prio);
        r.is_yield     = yld;
        r.is_current   = cur;
        pending_requests.push_back(r);
    endtask

    // sender: present the next request once the previous one is taken and its gap is over
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            tx_wait  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                update_ready_queues(tx_req);
                accepted_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    tx_req = pending_requests.pop_front();
                    s_tdata <= {2'b00, tx_req.is_current, tx_req.is_yield,
                                tx_req.priority_req, tx_req.thread_id};
                    s_tuser  <= tx_req.req_type;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = !tx_calm;
                    tx_wait = draw_gap(tx_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each result against the oldest prediction, then stall at random
    always @(posedge clk or negedge rst_n)
    begin
        pbrq_pkg::pbrq_result_t seen, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.became_running = m_tdata[0];
                seen.any_ready      = m_tdata[1];
                seen.best_thread    = m_tdata[7:2];
                seen.best_priority  = m_tdata[12:8];
                checked_count++;
                if (predicted_views.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: extra result run=%b rdy=%b thr=%0d lvl=%0d",
                                 $realtime, seen.became_running, seen.any_ready,
                                 seen.best_thread, seen.best_priority);
                end
                else
                begin
                    want = predicted_views.pop_front();
                    if (seen !== want)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: result %0d expected run=%b rdy=%b thr=%0d lvl=%0d",
                                     $realtime, checked_count,
                                     want.became_running, want.any_ready,
                                     want.best_thread, want.best_priority);
                            $display("%0t: result %0d actual   run=%b rdy=%b thr=%0d lvl=%0d",
                                     $realtime, checked_count,
                                     seen.became_running, seen.any_ready,
                                     seen.best_thread, seen.best_priority);
                        end
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_wait = draw_gap(rx_calm);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int roll, tid, prio;

        // remove from an empty scheduler, then a running-thread hit
        queue_request(pbrq_pkg::REQ_REMOVE, 5, 0, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 7, 3, 1'b0, 1'b1);
        // extremes of thread and level, then tail, head and tail links at level 0
        queue_request(pbrq_pkg::REQ_INSERT, 0, 31, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 63, 0, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 10, 0, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 11, 0, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 12, 0, 1'b1, 1'b0);
        // unlink from the middle, the head and the tail
        queue_request(pbrq_pkg::REQ_REMOVE, 10, 0, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_REMOVE, 11, 0, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_REMOVE, 12, 0, 1'b0, 1'b0);
        // not-scheduled priorities pull threads out and empty the bitmap
        queue_request(pbrq_pkg::REQ_INSERT, 63, 32, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 0, 63, 1'b0, 1'b0);
        // moves between levels; level 5 empties and must drop its bit
        queue_request(pbrq_pkg::REQ_INSERT, 20, 5, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 21, 5, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 20, 9, 1'b0, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 21, 9, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 21, 9, 1'b0, 1'b0);
        // a remove ignores is_current; a running hit leaves a queued thread alone
        queue_request(pbrq_pkg::REQ_REMOVE, 20, 0, 1'b0, 1'b1);
        queue_request(pbrq_pkg::REQ_INSERT, 21, 0, 1'b1, 1'b1);
        queue_request(pbrq_pkg::REQ_REMOVE, 21, 17, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_INSERT, 63, 31, 1'b1, 1'b0);
        queue_request(pbrq_pkg::REQ_REMOVE, 63, 63, 1'b1, 1'b1);

        // random part: mostly scheduled inserts over few threads and levels, so queues
        // grow deep, with removes, drains, running hits and fully random noise
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            roll = $urandom_range(0, 99);
            tid  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 63);
            prio = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 31);
            if (n % 250 == 249)
            begin
                // drain the busy threads in a rotated order
                roll = $urandom_range(0, 15);
                for (int k = 0; k < 16; k++)
                    queue_request(pbrq_pkg::REQ_REMOVE, (roll + k) % 16,
                                  $urandom_range(0, 63), 1'($urandom), 1'($urandom));
                n += 15;
            end
            else if (roll < 55)
                queue_request(pbrq_pkg::REQ_INSERT, tid, prio, 1'($urandom), 1'b0);
            else if (roll < 75)
                queue_request(pbrq_pkg::REQ_REMOVE, tid, $urandom_range(0, 63),
                              1'($urandom), 1'($urandom));
            else if (roll < 85)
                queue_request(pbrq_pkg::REQ_INSERT, tid, $urandom_range(32, 63),
                              1'($urandom), 1'b0);
            else if (roll < 92)
                queue_request(pbrq_pkg::REQ_INSERT, tid, $urandom_range(0, 63),
                              1'($urandom), 1'b1);
            else
                queue_request(1'($urandom), $urandom_range(0, 63), $urandom_range(0, 63),
                              1'($urandom), 1'($urandom));
        end
        total_requests = pending_requests.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count < total_requests || predicted_views.size() != 0)
            @(negedge clk);
        // let any stray result show up
        repeat (10) @(negedge clk);

        $display("Ran %0d requests: %0d inserts, %0d removes, %0d running-thread hits",
                 accepted_count, insert_count, remove_count, running_count);
        $display("Checked %0d results; up to %0d threads were queued at once",
                 checked_count, deepest_level);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #500000;
        $display("Timeout with %0d of %0d requests accepted", accepted_count, total_requests);
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/pbrq_pkg.sv
design/pbrq_prio_enc.sv
design/pbrq_queue_core.sv
design/priority_bitmap_ready_queues.sv
tb/priority_bitmap_ready_queues_tb.sv
